// ----- hdl/lis_pkg.sv -----
// lis_pkg: shared constants for the linear intercept solver.
// No dependencies; used by linear_intercept_solver, lis_div and the testbench.
package lis_pkg;

  localparam int SPEED_W   = 23;  // projectile speed register width
  localparam int TIME_W    = 32;  // hit_time width, Q16.16
  localparam int TIME_FRAC = 16;  // fraction bits of hit_time
  localparam int ROOT_SH   = 32;  // discriminant scaled by 2^32 before the root
  localparam int STATUS_W  = 3;
  localparam int USER_W    = 1 + STATUS_W;

  localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_DEGEN   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NEGDISC = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NEGTIME = 3'd3;
  localparam logic [STATUS_W-1:0] ST_OVF     = 3'd4;

endpackage

// ----- hdl/linear_intercept_solver.sv -----
// linear_intercept_solver: top level, pipelined constant-velocity intercept solve.
// Uses lis_pkg, lis_mulsub, lis_sqrt and lis_div.
//
//  channel  | dir | handshake                   | word
//  ---------+-----+-----------------------------+----------------------------------
//  cfg      | in  | cfg_valid / cfg_ready       | projectile_speed, 23 bits
//  s_axis   | in  | s_axis_tvalid / tready      | pos x,y,z, vel x,y,z
//  m_axis   | out | m_axis_tvalid / tready      | tdata: time, point; tuser: flags
//
// One word enters per cycle while m_axis is not stalled. The root takes one stage per
// root bit, with QW + 16 root bits where QW = max(2*COORD_WIDTH, 46) + 2, and the
// divider one stage per quotient bit.
// Reset (rst, synchronous) clears all valid bits and the speed register;
// both ready outputs stay low while rst is high.
// A stall on m_axis freezes the whole pipe; s_axis_tready follows it.
module linear_intercept_solver #(
  parameter int COORD_WIDTH = 24
) (
  input  logic                        clk,
  input  logic                        rst,
  // configuration write
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [lis_pkg::SPEED_W-1:0] cfg_data,      // projectile_speed
  // input words
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, zero pad
  input  logic [((6*COORD_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  // result words
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // hit_time, intercept_x, intercept_y, intercept_z, zero pad
  output logic [((lis_pkg::TIME_W+3*COORD_WIDTH+7)/8)*8-1:0] m_axis_tdata,
  // hit_found, status
  output logic [lis_pkg::USER_W-1:0]  m_axis_tuser
);

  localparam int W    = COORD_WIDTH;
  localparam int TW   = lis_pkg::TIME_W;
  localparam int SPW  = lis_pkg::SPEED_W;
  localparam int STW  = lis_pkg::STATUS_W;
  localparam int OUTW = ((TW + 3 * W + 7) / 8) * 8;
  localparam int PVW  = 6 * W;
  // a, h and c share one signed width
  localparam int QW   = ((2 * W > 2 * SPW) ? 2 * W : 2 * SPW) + 2;
  localparam int DW   = 2 * QW;
  localparam int XW   = DW + lis_pkg::ROOT_SH;
  localparam int RW   = XW / 2;
  localparam int NSW  = QW + 18;
  localparam int DENW = QW + 1;
  localparam int MSW  = PVW + 3 * QW;
  localparam int SQW  = MSW + 2;
  localparam int DVW  = PVW + STW + 1;
  localparam int OCW  = DENW + TW + 1;
  localparam int VTW  = W + TW + 1;
  localparam int PTW  = VTW - lis_pkg::TIME_FRAC + 1;

  logic en;
  logic [SPW-1:0] speed;

  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en && !rst;
  assign cfg_ready     = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      speed <= '0;
    end else if (cfg_valid) begin
      speed <= cfg_data;
    end
  end

  // ---- stage 1: component products
  logic signed [W-1:0]   in_p [3];
  logic signed [W-1:0]   in_v [3];
  logic                  s1_valid;
  logic [PVW-1:0]        s1_pv;
  logic signed [2*W-1:0] s1_pp [3];
  logic signed [2*W-1:0] s1_vv [3];
  logic signed [2*W-1:0] s1_ph [3];
  logic [2*SPW-1:0]      s1_ss;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      in_p[i] = s_axis_tdata[i*W +: W];
      in_v[i] = s_axis_tdata[(i+3)*W +: W];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= s_axis_tvalid;
    end
    if (en) begin
      s1_pv <= s_axis_tdata[PVW-1:0];
      for (int i = 0; i < 3; i++) begin
        s1_pp[i] <= in_p[i] * in_p[i];
        s1_vv[i] <= in_v[i] * in_v[i];
        s1_ph[i] <= in_p[i] * in_v[i];
      end
      s1_ss <= speed * speed;
    end
  end

  // ---- stage 2: a = |v|^2 - s^2, h = p.v, c = |p|^2
  logic                 s2_valid;
  logic [PVW-1:0]       s2_pv;
  logic signed [QW-1:0] s2_a, s2_h, s2_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en) begin
      s2_valid <= s1_valid;
    end
    if (en) begin
      s2_pv <= s1_pv;
      s2_a  <= QW'(s1_vv[0]) + QW'(s1_vv[1]) + QW'(s1_vv[2])
               - QW'($signed({1'b0, s1_ss}));
      s2_h  <= QW'(s1_ph[0]) + QW'(s1_ph[1]) + QW'(s1_ph[2]);
      s2_c  <= QW'(s1_pp[0]) + QW'(s1_pp[1]) + QW'(s1_pp[2]);
    end
  end

  // ---- stages 3-4: discriminant h^2 - a*c
  logic                 md_valid;
  logic signed [DW-1:0] md_d;
  logic [MSW-1:0]       md_side;

  lis_mulsub #(.OW(QW), .SW(MSW)) u_disc (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(s2_valid),
    .x0(s2_h), .y0(s2_h), .x1(s2_a), .y1(s2_c),
    .in_side({s2_pv, s2_a, s2_h, s2_c}),
    .out_valid(md_valid), .out_diff(md_d), .out_side(md_side)
  );

  // ---- root of D * 2^32; a negative D feeds zero
  logic                 md_dneg, md_lin;
  logic [XW-1:0]        sq_x;
  logic                 sq_valid;
  logic [RW-1:0]        sq_root;
  logic [SQW-1:0]       sq_side;

  assign md_dneg = md_d[DW-1];
  assign md_lin  = md_side[2*QW +: QW] == '0;
  assign sq_x    = md_dneg ? '0 : {md_d, {lis_pkg::ROOT_SH{1'b0}}};

  lis_sqrt #(.XW(XW), .SW(SQW)) u_root (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(md_valid), .in_x(sq_x),
    .in_side({md_side, md_lin, md_dneg}),
    .out_valid(sq_valid), .out_root(sq_root), .out_side(sq_side)
  );

  // ---- stage 6: root numerators N1 = R - h*2^16, N2 = -h*2^16 - R
  logic signed [QW-1:0]  sq_h;
  logic signed [NSW-1:0] sq_hs, sq_r;
  logic                  s6_valid;
  logic [SQW-1:0]        s6_side;
  logic signed [NSW-1:0] s6_n1, s6_n2;

  assign sq_h  = sq_side[2 + QW +: QW];
  assign sq_hs = NSW'(sq_h) <<< lis_pkg::TIME_FRAC;
  assign sq_r  = NSW'($signed({1'b0, sq_root}));

  always_ff @(posedge clk) begin
    if (rst) begin
      s6_valid <= 1'b0;
    end else if (en) begin
      s6_valid <= sq_valid;
    end
    if (en) begin
      s6_side <= sq_side;
      s6_n1   <= sq_r - sq_hs;
      s6_n2   <= -sq_hs - sq_r;
    end
  end

  // ---- stage 7: case split, root choice, numerator and denominator
  logic [PVW-1:0]        c7_pv;
  logic signed [QW-1:0]  c7_a, c7_h, c7_c;
  logic                  c7_lin, c7_dneg;
  logic                  a_neg, pos1, pos2, pick2, neg2;
  logic signed [NSW-1:0] n_sel;
  logic [STW-1:0]        c7_status;
  logic [NSW-1:0]        c7_num;
  logic [DENW-1:0]       c7_den;

  assign c7_dneg = s6_side[0];
  assign c7_lin  = s6_side[1];
  assign c7_c    = s6_side[2 +: QW];
  assign c7_h    = s6_side[2 + QW +: QW];
  assign c7_a    = s6_side[2 + 2*QW +: QW];
  assign c7_pv   = s6_side[2 + 3*QW +: PVW];

  always_comb begin
    a_neg = c7_a[QW-1];
    // root sign is numerator sign times sign of a
    pos1  = (s6_n1 != '0) && (s6_n1[NSW-1] == a_neg);
    pos2  = (s6_n2 != '0) && (s6_n2[NSW-1] == a_neg);
    neg2  = (s6_n2 != '0) && (s6_n2[NSW-1] != a_neg);
    pick2 = (pos1 && pos2) ? !a_neg : !pos1;
    n_sel = pick2 ? s6_n2 : s6_n1;
    c7_status = lis_pkg::ST_OK;
    if (c7_lin) begin
      c7_num = NSW'($unsigned(c7_c)) << lis_pkg::TIME_FRAC;
      c7_den = c7_h[QW-1] ? DENW'($unsigned(-c7_h)) << 1 : DENW'($unsigned(c7_h)) << 1;
      if (c7_h == '0) begin
        c7_status = lis_pkg::ST_DEGEN;
      end else if (!c7_h[QW-1] && c7_c != '0) begin
        c7_status = lis_pkg::ST_NEGTIME;
      end
    end else begin
      c7_num = n_sel[NSW-1] ? $unsigned(-n_sel) : $unsigned(n_sel);
      c7_den = a_neg ? DENW'($unsigned(-c7_a)) : DENW'($unsigned(c7_a));
      if (c7_dneg) begin
        c7_status = lis_pkg::ST_NEGDISC;
      end else if (pick2 && neg2) begin
        c7_status = lis_pkg::ST_NEGTIME;
      end
    end
  end

  logic             s7_valid;
  logic [PVW-1:0]   s7_pv;
  logic [STW-1:0]   s7_status;
  logic [NSW-1:0]   s7_num;
  logic [DENW-1:0]  s7_den;

  always_ff @(posedge clk) begin
    if (rst) begin
      s7_valid <= 1'b0;
    end else if (en) begin
      s7_valid <= s6_valid;
    end
    if (en) begin
      s7_pv     <= c7_pv;
      s7_status <= c7_status;
      s7_num    <= c7_num;
      s7_den    <= c7_den;
    end
  end

  // ---- stage 8: time overflow when num >= den * 2^32
  logic             s8_valid;
  logic [PVW-1:0]   s8_pv;
  logic [STW-1:0]   s8_status;
  logic             s8_ovf;
  logic [NSW-1:0]   s8_num;
  logic [DENW-1:0]  s8_den;

  always_ff @(posedge clk) begin
    if (rst) begin
      s8_valid <= 1'b0;
    end else if (en) begin
      s8_valid <= s7_valid;
    end
    if (en) begin
      s8_pv     <= s7_pv;
      s8_status <= s7_status;
      s8_num    <= s7_num;
      s8_den    <= s7_den;
      s8_ovf    <= OCW'(s7_num) >= (OCW'(s7_den) << TW);
    end
  end

  // ---- quotient
  logic           dv_valid;
  logic [TW-1:0]  dv_quo;
  logic [DVW-1:0] dv_side;

  lis_div #(.NW(NSW), .DW(DENW), .SW(DVW)) u_div (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(s8_valid), .in_num(s8_num), .in_den(s8_den),
    .in_side({s8_pv, s8_status, s8_ovf}),
    .out_valid(dv_valid), .out_quo(dv_quo), .out_side(dv_side)
  );

  // ---- stage 9: v * t
  logic                  dv_ovf;
  logic [TW-1:0]         dv_tq;
  logic [PVW-1:0]        dv_pv;
  logic signed [W-1:0]   dv_v [3];
  logic                  s9_valid;
  logic [PVW-1:0]        s9_pv;
  logic [STW-1:0]        s9_status;
  logic                  s9_ovf;
  logic [TW-1:0]         s9_tq;
  logic signed [VTW-1:0] s9_vt [3];

  assign dv_ovf = dv_side[0];
  assign dv_pv  = dv_side[1 + STW +: PVW];
  assign dv_tq  = dv_ovf ? '1 : dv_quo;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dv_v[i] = dv_pv[(i+3)*W +: W];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s9_valid <= 1'b0;
    end else if (en) begin
      s9_valid <= dv_valid;
    end
    if (en) begin
      s9_pv     <= dv_pv;
      s9_status <= dv_side[1 +: STW];
      s9_ovf    <= dv_ovf;
      s9_tq     <= dv_tq;
      for (int i = 0; i < 3; i++) begin
        s9_vt[i] <= dv_v[i] * $signed({1'b0, dv_tq});
      end
    end
  end

  // ---- stage 10: p + floor(v*t / 2^16), saturate, output register
  logic signed [PTW-1:0] pt  [3];
  logic [W-1:0]          pts [3];
  logic [2:0]            sat;
  logic                  out_ok;
  logic [W-1:0]          o_pt [3];
  logic [TW-1:0]         o_time;
  logic                  o_hit;
  logic [STW-1:0]        o_status;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pt[i]  = PTW'($signed(s9_pv[i*W +: W]))
               + PTW'(s9_vt[i] >>> lis_pkg::TIME_FRAC);
      sat[i] = !((&pt[i][PTW-1:W-1]) || !(|pt[i][PTW-1:W-1]));
      if (sat[i]) begin
        pts[i] = pt[i][PTW-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
      end else begin
        pts[i] = pt[i][W-1:0];
      end
    end
    out_ok = s9_status == lis_pkg::ST_OK;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      m_axis_tvalid <= s9_valid;
    end
    if (en) begin
      o_hit    <= out_ok;
      o_time   <= out_ok ? s9_tq : '0;
      for (int i = 0; i < 3; i++) begin
        o_pt[i] <= out_ok ? pts[i] : '0;
      end
      if (!out_ok) begin
        o_status <= s9_status;
      end else if (s9_ovf || (|sat)) begin
        o_status <= lis_pkg::ST_OVF;
      end else begin
        o_status <= lis_pkg::ST_OK;
      end
    end
  end

  assign m_axis_tdata = OUTW'({o_pt[2], o_pt[1], o_pt[0], o_time});
  assign m_axis_tuser = {o_status, o_hit};

endmodule

// ----- hdl/lis_mulsub.sv -----
// lis_mulsub: two-stage x0*y0 - x1*y1 on wide signed words, split into halves.
// Depends on nothing; side bits travel along with the product.
module lis_mulsub #(
  parameter int OW = 50,
  parameter int SW = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   in_valid,
  input  logic signed [OW-1:0]   x0,
  input  logic signed [OW-1:0]   y0,
  input  logic signed [OW-1:0]   x1,
  input  logic signed [OW-1:0]   y1,
  input  logic [SW-1:0]          in_side,
  output logic                   out_valid,
  output logic signed [2*OW-1:0] out_diff,
  output logic [SW-1:0]          out_side
);

  localparam int L  = OW / 2;
  localparam int HB = OW - L;
  localparam int PW = 2 * OW;

  logic signed [HB-1:0]  x0h, y0h, x1h, y1h;
  logic signed [L:0]     x0l, y0l, x1l, y1l;
  logic signed [2*HB-1:0] hh0, hh1;
  logic signed [HB+L:0]   hl0, lh0, hl1, lh1;
  logic signed [2*L+1:0]  ll0, ll1;
  logic                   v1;
  logic [SW-1:0]          side1;
  logic signed [PW-1:0]   prod0, prod1;

  assign x0h = x0[OW-1:L];
  assign y0h = y0[OW-1:L];
  assign x1h = x1[OW-1:L];
  assign y1h = y1[OW-1:L];
  assign x0l = $signed({1'b0, x0[L-1:0]});
  assign y0l = $signed({1'b0, y0[L-1:0]});
  assign x1l = $signed({1'b0, x1[L-1:0]});
  assign y1l = $signed({1'b0, y1[L-1:0]});

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
    if (en) begin
      hh0   <= x0h * y0h;
      hl0   <= x0h * y0l;
      lh0   <= x0l * y0h;
      ll0   <= x0l * y0l;
      hh1   <= x1h * y1h;
      hl1   <= x1h * y1l;
      lh1   <= x1l * y1h;
      ll1   <= x1l * y1l;
      side1 <= in_side;
    end
  end

  // recombine partial products
  assign prod0 = (PW'(hh0) <<< (2 * L)) + ((PW'(hl0) + PW'(lh0)) <<< L) + PW'(ll0);
  assign prod1 = (PW'(hh1) <<< (2 * L)) + ((PW'(hl1) + PW'(lh1)) <<< L) + PW'(ll1);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v1;
    end
    if (en) begin
      out_diff <= prod0 - prod1;
      out_side <= side1;
    end
  end

endmodule

// ----- hdl/lis_sqrt.sv -----
// lis_sqrt: pipelined floor square root, one root bit per stage.
// Depends on nothing; side bits travel along with the root.
module lis_sqrt #(
  parameter int XW = 132,
  parameter int SW = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  logic [XW-1:0]      in_x,
  input  logic [SW-1:0]      in_side,
  output logic               out_valid,
  output logic [XW/2-1:0]    out_root,
  output logic [SW-1:0]      out_side
);

  localparam int RW = XW / 2;
  localparam int RM = RW + 2;

  logic          vld  [0:RW];
  logic [RM-1:0] rem  [0:RW];
  logic [RW-1:0] root [0:RW];
  logic [XW-1:0] xs   [0:RW];
  logic [SW-1:0] side [0:RW];

  assign vld[0]  = in_valid;
  assign rem[0]  = '0;
  assign root[0] = '0;
  assign xs[0]   = in_x;
  assign side[0] = in_side;

  for (genvar k = 0; k < RW; k++) begin : g_stage
    logic [RM+1:0] cur, trial;
    logic          ge;

    assign cur   = {rem[k], xs[k][XW-1 -: 2]};
    assign trial = (RM + 2)'({root[k], 2'b01});
    assign ge    = cur >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
      if (en) begin
        rem[k+1]  <= ge ? RM'(cur - trial) : RM'(cur);
        root[k+1] <= {root[k][RW-2:0], ge};
        xs[k+1]   <= xs[k] << 2;
        side[k+1] <= side[k];
      end
    end
  end

  assign out_valid = vld[RW];
  assign out_root  = root[RW];
  assign out_side  = side[RW];

endmodule

// ----- hdl/lis_div.sv -----
// lis_div: pipelined restoring divider, one quotient bit per stage.
// Uses lis_pkg (quotient width); expects num < den * 2^TIME_W.
module lis_div #(
  parameter int NW = 68,
  parameter int DW = 51,
  parameter int SW = 8
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [NW-1:0]               in_num,
  input  logic [DW-1:0]               in_den,
  input  logic [SW-1:0]               in_side,
  output logic                        out_valid,
  output logic [lis_pkg::TIME_W-1:0]  out_quo,
  output logic [SW-1:0]               out_side
);

  localparam int QB = lis_pkg::TIME_W;
  localparam int CW = ((NW > DW + QB) ? NW : DW + QB) + 1;

  logic          vld  [0:QB];
  logic [NW-1:0] rem  [0:QB];
  logic [DW-1:0] den  [0:QB];
  logic [QB-1:0] quo  [0:QB];
  logic [SW-1:0] side [0:QB];

  assign vld[0]  = in_valid;
  assign rem[0]  = in_num;
  assign den[0]  = in_den;
  assign quo[0]  = '0;
  assign side[0] = in_side;

  for (genvar k = 0; k < QB; k++) begin : g_stage
    localparam int B = QB - 1 - k;
    logic [CW-1:0] r_ext, d_sh, diff;
    logic          ge;

    assign r_ext = CW'(rem[k]);
    assign d_sh  = CW'(den[k]) << B;
    assign ge    = r_ext >= d_sh;
    assign diff  = r_ext - d_sh;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
      if (en) begin
        rem[k+1]  <= ge ? NW'(diff) : rem[k];
        den[k+1]  <= den[k];
        quo[k+1]  <= quo[k] | (QB'(ge) << B);
        side[k+1] <= side[k];
      end
    end
  end

  assign out_valid = vld[QB];
  assign out_quo   = quo[QB];
  assign out_side  = side[QB];

endmodule

// ----- dv/tb_linear_intercept_solver.sv -----
// Self-checking testbench for linear_intercept_solver: random and directed target words,
// exact-integer intercept prediction, in-order comparison of result words.
// Depends on hdl/lis_pkg.sv and hdl/linear_intercept_solver.sv.
module tb_linear_intercept_solver;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW       = 24;
  localparam int TW       = lis_pkg::TIME_W;
  localparam int SPW      = lis_pkg::SPEED_W;
  localparam int STW      = lis_pkg::STATUS_W;
  localparam int UW       = lis_pkg::USER_W;
  localparam int IN_W     = ((6*CW+7)/8)*8;
  localparam int OUT_W    = ((TW+3*CW+7)/8)*8;
  localparam int LATENCY  = 107;
  localparam int LIMIT    = 400000;
  localparam int RX_HOLD  = 400;            // long receiver hold-off, cycles
  localparam logic [SPW-1:0] SPEED_MAX = '1;

  typedef logic signed [255:0] wide_t;      // room for D * 2^32 and its square checks

  typedef struct {
    logic signed [CW-1:0] pos [3];
    logic signed [CW-1:0] vel [3];
  } target_t;

  typedef struct {
    logic                 found;
    logic [STW-1:0]       status;
    logic [TW-1:0]        t;
    logic signed [CW-1:0] pt [3];
  } intercept_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [SPW-1:0] cfg_data = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_W-1:0] s_axis_tdata = '0;       // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;           // hit_time, intercept_x, intercept_y, intercept_z
  logic [UW-1:0] m_axis_tuser;              // hit_found, status

  linear_intercept_solver #(.COORD_WIDTH(CW)) u_top (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  target_t           pending_targets [$];
  intercept_t        expected_hits [$];
  logic [SPW-1:0]    speed_writes [$];
  logic [SPW-1:0]    speed_now = '0;        // our copy of projectile_speed
  int errors = 0;
  int words_sent = 0;
  int words_seen = 0;
  int cycles = 0;

  // ---------------------------------------------------------------------------
  // Intercept predictor, exact integers.
  // a = |v|^2 - s^2, h = p.v, c = |p|^2 (products of input units)
  // ---------------------------------------------------------------------------
  function automatic wide_t isqrt(wide_t n);
    wide_t r, t;
    r = '0;
    for (int i = 100; i >= 0; i--) begin
      t = r | (wide_t'(1) <<< i);
      if (t * t <= n) r = t;
    end
    return r;
  endfunction

  function automatic int sgn(wide_t x);
    return (x == 0) ? 0 : ((x < 0) ? -1 : 1);
  endfunction

  function automatic intercept_t solve_intercept(target_t tg, logic [SPW-1:0] spd);
    intercept_t res;
    wide_t a, h, c, d, r, hs, n1, n2, num, den, q, vt, p;
    logic [STW-1:0] st;
    logic [TW-1:0] tq;
    logic ovf;
    int sa, s1, s2;
    bit take_second;
    a = '0; h = '0; c = '0; num = '0; den = wide_t'(1);
    st = lis_pkg::ST_OK;
    for (int i = 0; i < 3; i++) begin
      a += wide_t'(tg.vel[i]) * wide_t'(tg.vel[i]);
      c += wide_t'(tg.pos[i]) * wide_t'(tg.pos[i]);
      h += wide_t'(tg.pos[i]) * wide_t'(tg.vel[i]);
    end
    a -= wide_t'(spd) * wide_t'(spd);
    if (a == 0) begin
      // linear case: t = -c / 2h
      if (h == 0) st = lis_pkg::ST_DEGEN;
      else if (h > 0 && c != 0) st = lis_pkg::ST_NEGTIME;
      else begin
        num = c <<< 16;
        den = 2 * ((h < 0) ? -h : h);
      end
    end else begin
      d = h * h - a * c;
      if (d < 0) st = lis_pkg::ST_NEGDISC;
      else begin
        r  = isqrt(d <<< 32);
        hs = h <<< 16;
        n1 = r - hs;
        n2 = -hs - r;
        sa = (a < 0) ? -1 : 1;
        s1 = sgn(n1) * sa;
        s2 = sgn(n2) * sa;
        // both roots ahead: earlier one; else first positive; else second
        if (s1 > 0 && s2 > 0) take_second = (sa > 0);
        else take_second = !(s1 > 0);
        if (take_second && s2 < 0) st = lis_pkg::ST_NEGTIME;
        else begin
          num = take_second ? n2 : n1;
          if (num < 0) num = -num;
          den = (a < 0) ? -a : a;
        end
      end
    end
    res.found = 1'b0;
    res.status = st;
    res.t = '0;
    for (int i = 0; i < 3; i++) res.pt[i] = '0;
    if (st != lis_pkg::ST_OK) return res;
    q = num / den;
    ovf = (q >= (wide_t'(1) <<< 32));
    tq = ovf ? '1 : q[TW-1:0];
    for (int i = 0; i < 3; i++) begin
      vt = wide_t'(tg.vel[i]) * wide_t'(tq);
      p  = wide_t'(tg.pos[i]) + (vt >>> lis_pkg::TIME_FRAC);     // floor step
      if (p > wide_t'(2**(CW-1) - 1)) begin
        p = wide_t'(2**(CW-1) - 1); ovf = 1'b1;
      end
      if (p < -wide_t'(2**(CW-1))) begin
        p = -wide_t'(2**(CW-1)); ovf = 1'b1;
      end
      res.pt[i] = p[CW-1:0];
    end
    res.found = 1'b1;
    res.status = ovf ? lis_pkg::ST_OVF : lis_pkg::ST_OK;
    res.t = tq;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Config channel: one write at a time from speed_writes
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        speed_now = cfg_data;
        cfg_valid <= 1'b0;
      end else if (!cfg_valid && speed_writes.size() > 0) begin
        cfg_data  <= speed_writes.pop_front();
        cfg_valid <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Driver: presents target words; predicts on acceptance.
  // Idles ~21% of cycles, except for a stretch of words with no gaps.
  // ---------------------------------------------------------------------------
  target_t cur_target;

  always @(posedge clk) begin
    logic busy, gap;
    target_t nx;
    if (!rst) begin
      busy = s_axis_tvalid;
      if (s_axis_tvalid && s_axis_tready) begin
        expected_hits.push_back(solve_intercept(cur_target, speed_now));
        words_sent++;
        busy = 1'b0;
      end
      gap = ($urandom_range(99) < 21) && !(words_sent >= 600 && words_sent < 900);
      if (!busy && pending_targets.size() > 0 && !gap) begin
        nx = pending_targets.pop_front();
        cur_target = nx;
        s_axis_tdata  <= {nx.vel[2], nx.vel[1], nx.vel[0], nx.pos[2], nx.pos[1], nx.pos[0]};
        s_axis_tvalid <= 1'b1;
      end else if (!busy) begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks result words in order and drives tready.
  // After 200 results it holds tready low long enough to fill the pipe.
  // ---------------------------------------------------------------------------
  int  hold_left = 0;
  bit  hold_done = 1'b0;

  always @(posedge clk) begin
    intercept_t exp_hit;
    logic [TW-1:0] got_t;
    logic signed [CW-1:0] got_pt [3];
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        words_seen++;
        got_t = m_axis_tdata[TW-1:0];
        for (int i = 0; i < 3; i++) got_pt[i] = m_axis_tdata[TW + i*CW +: CW];
        if (expected_hits.size() == 0) begin
          $error("unexpected result word: tdata=%h tuser=%h", m_axis_tdata, m_axis_tuser);
          errors++;
        end else begin
          exp_hit = expected_hits.pop_front();
          if (m_axis_tuser[0] !== exp_hit.found) begin
            $error("hit_found: expected %0d, got %0d", exp_hit.found, m_axis_tuser[0]);
            errors++;
          end
          if (m_axis_tuser[UW-1:1] !== exp_hit.status) begin
            $error("status: expected %0d, got %0d", exp_hit.status, m_axis_tuser[UW-1:1]);
            errors++;
          end
          if (got_t !== exp_hit.t) begin
            $error("hit_time: expected %h, got %h", exp_hit.t, got_t);
            errors++;
          end
          for (int i = 0; i < 3; i++)
            if (got_pt[i] !== exp_hit.pt[i]) begin
              $error("intercept_%s: expected %0d, got %0d",
                     (i == 0) ? "x" : (i == 1) ? "y" : "z", exp_hit.pt[i], got_pt[i]);
              errors++;
            end
        end
      end
      if (!hold_done && words_seen == 200) begin
        hold_done = 1'b1;
        hold_left = RX_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= !(($urandom_range(99) < 21) && !(words_seen >= 700 && words_seen < 1000));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("linear_intercept_solver: mismatch");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  function automatic logic signed [CW-1:0] pick_coord(int mode);
    case (mode)
      0: return CW'($urandom());                                          // full range
      1: return CW'($signed(CW'($urandom_range(8191))) - 4096);           // small
      default: begin
        case ($urandom_range(4))
          0: return {1'b0, {(CW-1){1'b1}}};
          1: return {1'b1, {(CW-1){1'b0}}};
          2: return '0;
          3: return '1;
          default: return CW'(1);
        endcase
      end
    endcase
  endfunction

  task automatic add_target(int px, int py, int pz, int vx, int vy, int vz);
    target_t tg;
    tg.pos[0] = CW'(px); tg.pos[1] = CW'(py); tg.pos[2] = CW'(pz);
    tg.vel[0] = CW'(vx); tg.vel[1] = CW'(vy); tg.vel[2] = CW'(vz);
    pending_targets.push_back(tg);
  endtask

  task automatic add_random(int n, logic [SPW-1:0] spd);
    target_t tg;
    int mode, ax;
    repeat (n) begin
      mode = $urandom_range(99);
      for (int i = 0; i < 3; i++) begin
        tg.pos[i] = pick_coord(mode < 20 ? 0 : mode < 85 ? 1 : 2);
        tg.vel[i] = pick_coord(mode < 20 ? 0 : mode < 85 ? 1 : 2);
      end
      // target speed equal to projectile speed: linear case
      if (mode >= 65 && mode < 85 && spd <= SPW'(2**(CW-1) - 1)) begin
        ax = $urandom_range(2);
        for (int i = 0; i < 3; i++) tg.vel[i] = '0;
        tg.vel[ax] = $urandom_range(1) ? $signed({1'b0, spd}) : -$signed({1'b0, spd});
      end
      pending_targets.push_back(tg);
    end
  endtask

  task automatic drain();
    while (pending_targets.size() > 0 || s_axis_tvalid || expected_hits.size() > 0)
      @(posedge clk);
    repeat (LATENCY + 20) @(posedge clk);
  endtask

  task automatic set_speed(logic [SPW-1:0] spd);
    speed_writes.push_back(spd);
    while (speed_writes.size() > 0 || cfg_valid) @(posedge clk);
  endtask

  initial begin
    logic [SPW-1:0] speeds [6];
    speeds = '{SPW'(1280), SPEED_MAX, SPW'(1), SPW'(12800), '0, '0};
    speeds[5] = SPW'($urandom_range(65535));
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset speed is zero: still target gives degenerate, closing target a double root
    add_target(0, 0, 0, 0, 0, 0);
    add_target(256, 0, 0, -256, 0, 0);
    add_random(150, '0);
    drain();

    foreach (speeds[k]) begin
      set_speed(speeds[k]);
      if (k == 0) begin
        add_target(2560, 0, 0, 1280, 0, 0);     // receding at shot speed: negative time
        add_target(2560, 0, 0, -1280, 0, 0);    // approaching at shot speed: linear hit
        add_target(0, 0, 0, 1280, 0, 0);        // at origin, h zero: degenerate
        add_target(0, 2560, 0, 25600, 0, 0);    // faster target, h zero: no real root
        add_target(2560, 0, 0, 2560, 0, 0);     // faster and receding: negative time
        add_target(-2560, 0, 0, 1281, 0, 0);    // barely faster, approaching: hit time just under 1
        add_target(8388607, 8388607, 8388607, 8388607, 8388607, 8388607);
        add_target(-8388608, -8388608, -8388608, -8388608, -8388608, -8388608);
        add_target(8388607, -8388608, 0, -8388608, 8388607, -1);
        add_target(-8388608, 0, 8388607, 1, -1, 0);
        add_target(0, 0, 0, 0, 0, 0);           // at origin: zero time hit
        add_target(2560, 0, 0, -256, 0, 0);
      end
      add_random(k == 5 ? 160 : 230, speeds[k]);
      drain();
    end

    if (errors == 0) begin
      $display("linear_intercept_solver: match");
    end else begin
      $display("linear_intercept_solver: mismatch");
    end
    $finish;
  end

endmodule

// ----- linear_intercept_solver.f -----
hdl/lis_pkg.sv
hdl/lis_mulsub.sv
hdl/lis_sqrt.sv
hdl/lis_div.sv
hdl/linear_intercept_solver.sv
dv/tb_linear_intercept_solver.sv
